FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent assertion wrappers, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mic_pkg.sv
// ---------------------------------------------------------------------------
// mic_pkg
// Types, constants and helper functions of the matrix inverse core.
// ---------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

	localparam int MAX_ORDER = 4;
	localparam int MEM_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int ELEM_W    = 12;
	localparam int PROD_W    = 36;   // product of three elements
	localparam int COF_W     = 37;   // 3x3 minor determinant
	localparam int DET_W     = 50;   // internal determinant, full range
	localparam int DETO_W    = 49;   // determinant as reported
	localparam int DVS_W     = 49;   // determinant magnitude
	localparam int INV_W     = 52;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = 52;
	localparam int DIV_CW    = 6;

	localparam logic [INV_W-1:0] INV_MAX     = {1'b0, {(INV_W-1){1'b1}}};
	localparam logic [INV_W-1:0] INV_MIN_MAG = {1'b1, {(INV_W-1){1'b0}}};

	// datapath operation on the registered factor
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_FIRST = 3'd1,
		OP_MUL   = 3'd2,
		OP_LAST  = 3'd3,
		OP_STORE = 3'd4
	} op_t;

	typedef struct packed {
		logic       ld_en;
		logic [3:0] ld_addr;
		op_t        op;
		logic [3:0] rd_addr;
		logic       use_const;
		logic       const_one;
		logic       clr;
		logic       neg;
		logic       det_add;
		logic [3:0] cof_addr;
		logic       det_clr;
		logic       cof_rd_en;
		logic [3:0] cof_rd_addr;
		logic       div_start;
		logic       out_load;
		logic       out_sing;
		logic [1:0] out_row;
		logic [1:0] out_col;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_sts_t;

	// column picked in row k by permutation p of three
	function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
		logic [5:0] cols;
		begin
			case (p)
				3'd0:    cols = {2'd2, 2'd1, 2'd0};
				3'd1:    cols = {2'd1, 2'd2, 2'd0};
				3'd2:    cols = {2'd2, 2'd0, 2'd1};
				3'd3:    cols = {2'd0, 2'd2, 2'd1};
				3'd4:    cols = {2'd1, 2'd0, 2'd2};
				3'd5:    cols = {2'd0, 2'd1, 2'd2};
				default: cols = {2'd2, 2'd1, 2'd0};
			endcase
			case (k)
				2'd0:    perm_col = cols[1:0];
				2'd1:    perm_col = cols[3:2];
				default: perm_col = cols[5:4];
			endcase
		end
	endfunction

	// odd permutation
	function automatic logic perm_odd(input logic [2:0] p);
		begin
			perm_odd = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mic_divider.sv
// ---------------------------------------------------------------------------
// mic_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mic_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mic_pkg::INV_W-1:0]   dividend,
	input  wire logic [mic_pkg::DVS_W-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic [mic_pkg::INV_W-1:0]        quotient
);
	import mic_pkg::*;

	logic [INV_W-1:0]  quo_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0]    rem_sh;
	logic [DVS_W:0]    rem_diff;
	logic              fits;

	// trial subtraction
	assign rem_sh   = {rem_q[DVS_W-1:0], quo_q[INV_W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign fits     = rem_sh >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CW'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[INV_W-2:0], fits};
			rem_q <= fits ? rem_diff : rem_sh;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/mic_datapath.sv
// ---------------------------------------------------------------------------
// mic_datapath
// Matrix store, minor product unit, cofactor store, determinant and output.
// ---------------------------------------------------------------------------
`default_nettype none

module mic_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mic_pkg::dp_cmd_t                  cmd,
	input  wire logic signed [mic_pkg::ELEM_W-1:0] element_value,
	input  wire logic                              out_stall,
	output mic_pkg::dp_sts_t                       sts,
	output logic                                   out_valid,
	output logic [1:0]                             row_index,
	output logic [1:0]                             col_index,
	output logic signed [mic_pkg::INV_W-1:0]       inverse_value,
	output logic signed [mic_pkg::DETO_W-1:0]      det_value,
	output logic                                   singular,
	output logic                                   last_entry
);
	import mic_pkg::*;

	logic signed [ELEM_W-1:0] mat_mem [MEM_DEPTH];
	logic signed [COF_W-1:0]  cof_mem [MEM_DEPTH];

	dp_cmd_t                  cmd_s1;
	logic signed [ELEM_W-1:0] rd_s1;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COF_W-1:0]  cof_acc_q;
	logic signed [DET_W-1:0]  det_acc_q;
	logic signed [COF_W-1:0]  cof_rd_q;
	logic                     neg_q;
	logic                     out_valid_q;

	logic signed [ELEM_W-1:0]        factor;
	logic signed [PROD_W+ELEM_W-1:0] mul_w;
	logic signed [COF_W+ELEM_W-1:0]  dmul_w;
	logic [COF_W-1:0]                cof_mag;
	logic [DET_W-1:0]                det_mag;
	logic                            div_busy;
	logic                            div_done;
	logic [INV_W-1:0]                quo;
	logic [INV_W-1:0]                inv_conv;
	logic                            out_free;

	// matrix store: load writes, registered read for the product unit
	always_ff @(posedge clk) begin
		if (cmd.ld_en) begin
			mat_mem[cmd.ld_addr] <= element_value;
		end
		rd_s1 <= mat_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	// factor of the padded minor: store element or identity fill
	always_comb begin
		if (cmd_s1.use_const) begin
			factor = cmd_s1.const_one ? ELEM_W'(1) : '0;
		end else begin
			factor = rd_s1;
		end
	end

	assign mul_w  = prod_q * factor;
	assign dmul_w = cof_acc_q * factor;

	// term products and cofactor accumulation
	always_ff @(posedge clk) begin
		case (cmd_s1.op)
			OP_FIRST: begin
				prod_q <= PROD_W'(factor);
				if (cmd_s1.clr) begin
					cof_acc_q <= '0;
				end
			end
			OP_MUL: begin
				prod_q <= mul_w[PROD_W-1:0];
			end
			OP_LAST: begin
				if (cmd_s1.neg) begin
					cof_acc_q <= cof_acc_q - COF_W'($signed(mul_w[PROD_W-1:0]));
				end else begin
					cof_acc_q <= cof_acc_q + COF_W'($signed(mul_w[PROD_W-1:0]));
				end
			end
			OP_STORE: begin
				cof_mem[cmd_s1.cof_addr] <= cof_acc_q;
			end
			default: begin
			end
		endcase
		if (cmd.cof_rd_en) begin
			cof_rd_q <= cof_mem[cmd.cof_rd_addr];
		end
	end

	// determinant by expansion along the first row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_acc_q <= '0;
		end else if (cmd_s1.det_clr) begin
			det_acc_q <= '0;
		end else if (cmd_s1.op == OP_STORE && cmd_s1.det_add) begin
			det_acc_q <= det_acc_q + DET_W'(dmul_w);
		end
	end

	// operand magnitudes for the divider
	assign cof_mag = cof_rd_q[COF_W-1] ? COF_W'(-cof_rd_q) : COF_W'(cof_rd_q);
	assign det_mag = det_acc_q[DET_W-1] ? DET_W'(-det_acc_q) : DET_W'(det_acc_q);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= cof_rd_q[COF_W-1] ^ det_acc_q[DET_W-1];
		end
	end

	mic_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({cof_mag[INV_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}),
		.divisor  (det_mag[DVS_W-1:0]),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// sign and saturation of the quotient
	always_comb begin
		if (!neg_q) begin
			inv_conv = (quo > INV_MAX) ? INV_MAX : quo;
		end else begin
			inv_conv = (quo > INV_MIN_MAG) ? INV_MIN_MAG : INV_W'(-quo);
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			row_index  <= cmd.out_row;
			col_index  <= cmd.out_col;
			singular   <= cmd.out_sing;
			last_entry <= cmd.out_last;
			if (cmd.out_sing) begin
				inverse_value <= '0;
				det_value     <= '0;
			end else begin
				inverse_value <= inv_conv;
				det_value     <= det_acc_q[DETO_W-1:0];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.det_zero = (det_acc_q == '0);
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;

endmodule

`default_nettype wire

FILE: rtl/core/mic_ctrl.sv
// ---------------------------------------------------------------------------
// mic_ctrl
// Sequencer: loading, cofactor terms, determinant steps and division order.
// ---------------------------------------------------------------------------
`default_nettype none

module mic_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write_en,
	input  wire logic [2:0]       cfg_write_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire mic_pkg::dp_sts_t sts,
	output mic_pkg::dp_cmd_t      cmd
);
	import mic_pkg::*;

	typedef enum logic [8:0] {
		S_LOAD  = 9'b000000001,
		S_CLR   = 9'b000000010,
		S_TERM  = 9'b000000100,
		S_STORE = 9'b000001000,
		S_FLUSH = 9'b000010000,
		S_CHK   = 9'b000100000,
		S_DRD   = 9'b001000000,
		S_DST   = 9'b010000000,
		S_DWAIT = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] order_q;
	logic [4:0] load_cnt_q, load_cnt_d;
	logic [1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [2:0] p_q, p_d;

	logic [2:0] n_eff;
	logic [1:0] n_m1;
	logic [4:0] total;
	logic       in_acc;
	logic [1:0] l_col;
	logic [1:0] rk;
	logic [1:0] cl;
	logic [4:0] addr_w;
	logic       at_end;

	// effective order, clamped to 1..MAX_ORDER
	always_comb begin
		if (order_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (order_q > 3'(MAX_ORDER)) begin
			n_eff = 3'(MAX_ORDER);
		end else begin
			n_eff = order_q;
		end
	end

	assign n_m1   = 2'(n_eff - 3'd1);
	assign total  = 5'(n_eff) * 5'(n_eff);
	assign in_acc = in_valid && (state_q == S_LOAD);
	assign at_end = (i_q == n_m1) && (j_q == n_m1);

	// padded minor element: source row and column in the full matrix
	assign l_col  = perm_col(p_q, k_q);
	assign rk     = (k_q < i_q) ? k_q : 2'(k_q + 2'd1);
	assign cl     = (l_col < j_q) ? l_col : 2'(l_col + 2'd1);
	assign addr_w = 5'(rk) * 5'(n_eff) + 5'(cl);

	always_comb begin
		state_d    = state_q;
		load_cnt_d = load_cnt_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		p_d        = p_q;
		cmd        = '0;
		cmd.op     = OP_NONE;

		cmd.ld_en   = in_acc;
		cmd.ld_addr = load_cnt_q[3:0];

		unique case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					if (5'(load_cnt_q + 5'd1) == total) begin
						load_cnt_d = '0;
						i_d        = '0;
						j_d        = '0;
						k_d        = '0;
						p_d        = '0;
						state_d    = S_CLR;
					end else begin
						load_cnt_d = load_cnt_q + 5'd1;
					end
				end
			end
			S_CLR: begin
				cmd.det_clr = 1'b1;
				state_d     = S_TERM;
			end
			// one factor of one permutation term per cycle
			S_TERM: begin
				cmd.rd_addr   = addr_w[3:0];
				cmd.use_const = !((k_q < n_m1) && (l_col < n_m1));
				cmd.const_one = (k_q == l_col);
				cmd.clr       = (k_q == 2'd0) && (p_q == 3'd0);
				cmd.neg       = perm_odd(p_q) ^ i_q[0] ^ j_q[0];
				if (k_q == 2'd0) begin
					cmd.op = OP_FIRST;
				end else if (k_q == 2'd1) begin
					cmd.op = OP_MUL;
				end else begin
					cmd.op = OP_LAST;
				end
				if (k_q == 2'd2) begin
					k_d = '0;
					if (p_q == 3'd5) begin
						p_d     = '0;
						state_d = S_STORE;
					end else begin
						p_d = p_q + 3'd1;
					end
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			// write cofactor; first row also adds into the determinant
			S_STORE: begin
				cmd.op       = OP_STORE;
				cmd.rd_addr  = {2'b00, j_q};
				cmd.cof_addr = {i_q, j_q};
				cmd.det_add  = (i_q == 2'd0);
				if (j_q == n_m1) begin
					j_d = '0;
					if (i_q == n_m1) begin
						i_d     = '0;
						state_d = S_FLUSH;
					end else begin
						i_d     = i_q + 2'd1;
						state_d = S_TERM;
					end
				end else begin
					j_d     = j_q + 2'd1;
					state_d = S_TERM;
				end
			end
			S_FLUSH: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.det_zero) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sing = 1'b1;
						cmd.out_last = 1'b1;
						state_d      = S_LOAD;
					end
				end else begin
					state_d = S_DRD;
				end
			end
			// entry (r,c) uses the transposed cofactor
			S_DRD: begin
				cmd.cof_rd_en   = 1'b1;
				cmd.cof_rd_addr = {j_q, i_q};
				state_d         = S_DST;
			end
			S_DST: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_row  = i_q;
					cmd.out_col  = j_q;
					cmd.out_last = at_end;
					if (at_end) begin
						i_d     = '0;
						j_d     = '0;
						state_d = S_LOAD;
					end else begin
						state_d = S_DRD;
						if (j_q == n_m1) begin
							j_d = '0;
							i_d = i_q + 2'd1;
						end else begin
							j_d = j_q + 2'd1;
						end
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			order_q    <= 3'd4;
			load_cnt_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			p_q        <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			p_q     <= p_d;
			// order write drops any partial load
			if (cfg_write_en) begin
				order_q    <= cfg_write_data;
				load_cnt_q <= '0;
			end else begin
				load_cnt_q <= load_cnt_d;
			end
		end
	end

	assign in_stall = (state_q != S_LOAD);

endmodule

`default_nettype wire

FILE: rtl/core/matrix_inverse_cofactor_core.sv
// ---------------------------------------------------------------------------
// matrix_inverse_cofactor_core
// Square matrix inverse by adjugate with exact determinant, Q35.16 output.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | element_value
//  out     | out_valid / out_stall| row_index col_index inverse_value det_value
//          |                      | singular last_entry
//  cfg     | cfg_write_en         | cfg_write_data (matrix order)
//
//  Elements load one per cycle while in_stall is low; the last one of an n x n
//  matrix starts compute. Cofactors: six three-factor terms and a store each, n*n of them.
//  Inverse entries are computed one at a time by the bit-serial divider.
//  Input stalls from the last element until the final result is registered.
//  Results wait in an output register while out_stall is high.
//  Reset clears the load count, the determinant and sets the order to 4.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module matrix_inverse_cofactor_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write_en,
	input  wire logic [2:0]                        cfg_write_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [mic_pkg::ELEM_W-1:0] element_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             row_index,
	output logic [1:0]                             col_index,
	output logic signed [mic_pkg::INV_W-1:0]       inverse_value,
	output logic signed [mic_pkg::DETO_W-1:0]      det_value,
	output logic                                   singular,
	output logic                                   last_entry
);
	import mic_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mic_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sts            (sts),
		.cmd            (cmd)
	);

	mic_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.element_value (element_value),
		.out_stall     (out_stall),
		.sts           (sts),
		.out_valid     (out_valid),
		.row_index     (row_index),
		.col_index     (col_index),
		.inverse_value (inverse_value),
		.det_value     (det_value),
		.singular      (singular),
		.last_entry    (last_entry)
	);

	// singular result carries nothing but the flags
	`AST_IMPL(a_sing_res, clk, arst_n, out_valid && singular, (inverse_value == '0) && last_entry, "singular result malformed")
	// no element transfer while the divider runs
	`AST_IMPL(a_div_stall, clk, arst_n, sts.div_busy, in_stall, "input open during division")
	// a regular result always has a nonzero determinant
	`AST_IMPL(a_det_nz, clk, arst_n, out_valid && !singular, det_value != '0, "zero determinant on inverse entry")

endmodule

`default_nettype wire
